// File: hdl/sia_pkg.sv
package sia_pkg;

    // Command codes
    localparam logic [4:0] CMD_POW = 5'd0;
    localparam logic [4:0] CMD_MUL = 5'd1;
    localparam logic [4:0] CMD_DIV = 5'd2;
    localparam logic [4:0] CMD_MOD = 5'd3;
    localparam logic [4:0] CMD_ADD = 5'd4;
    localparam logic [4:0] CMD_SUB = 5'd5;
    localparam logic [4:0] CMD_SHL = 5'd6;
    localparam logic [4:0] CMD_SHR = 5'd7;
    localparam logic [4:0] CMD_LT  = 5'd8;
    localparam logic [4:0] CMD_LE  = 5'd9;
    localparam logic [4:0] CMD_GT  = 5'd10;
    localparam logic [4:0] CMD_GE  = 5'd11;
    localparam logic [4:0] CMD_EQ  = 5'd12;
    localparam logic [4:0] CMD_NE  = 5'd13;
    localparam logic [4:0] CMD_AND = 5'd14;
    localparam logic [4:0] CMD_XOR = 5'd15;
    localparam logic [4:0] CMD_OR  = 5'd16;
    localparam logic [4:0] CMD_POS = 5'd17;
    localparam logic [4:0] CMD_NEG = 5'd18;
    localparam logic [4:0] CMD_NOT = 5'd19;

    // Error codes
    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_DIV_ZERO     = 3'd1;
    localparam logic [2:0] ERR_ZERO_NEG_POW = 3'd2;
    localparam logic [2:0] ERR_POW_BIG      = 3'd3;
    localparam logic [2:0] ERR_SHIFT        = 3'd4;
    localparam logic [2:0] ERR_DIV_OVF      = 3'd5;

    // Operation class carried down the pipeline
    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_MUL  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;
    localparam logic [1:0] KIND_POW  = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       is_div;   // quotient rather than remainder
        logic       neg;      // negate the magnitude at the end
        logic       is_bool;
        logic [2:0] err;
    } ctrl_t;

endpackage

// File: hdl/sia_pow_cell.sv
module sia_pow_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  sia_pkg::ctrl_t                    ctrl_i,
    input  logic [DATA_WIDTH-1:0]             res_i,
    input  logic [DATA_WIDTH-1:0]             x_i,
    input  logic [DATA_WIDTH-1:0]             y_i,
    input  logic [DATA_WIDTH-1:0]             z_i,
    input  logic [$clog2(DATA_WIDTH)-1:0]     exp_i,
    input  logic                              dead_i,
    output sia_pkg::ctrl_t                    ctrl_o,
    output logic [DATA_WIDTH-1:0]             res_o,
    output logic [DATA_WIDTH-1:0]             x_o,
    output logic [DATA_WIDTH-1:0]             y_o,
    output logic [DATA_WIDTH-1:0]             z_o,
    output logic [$clog2(DATA_WIDTH)-1:0]     exp_o,
    output logic                              dead_o
);
    import sia_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int HW  = (W + 1) / 2;
    localparam int EW  = $clog2(W);
    localparam int P2W = 2 * HW;
    localparam int PW  = W + HW + 1;

    // stage A: partial products (res holds r, z holds the running base)
    ctrl_t          ctrl_a_reg;
    logic [W-1:0]   res_a_reg, x_a_reg, y_a_reg, z_a_reg;
    logic [EW-1:0]  exp_a_reg;
    logic           dead_a_reg, big_a_reg, bsmall_a_reg;
    logic [P2W-1:0] plo_a_reg, sq_a_reg;
    logic [W-1:0]   phi_a_reg;

    logic           r_small, b_small;
    logic [HW-1:0]  s_op;
    logic [W-1:0]   l_op;

    // stage B
    ctrl_t          ctrl_b_reg, ctrl_b_next;
    logic [W-1:0]   res_b_reg, res_b_next, z_b_reg, z_b_next, x_b_reg, y_b_reg;
    logic [EW-1:0]  exp_b_reg;
    logic           dead_b_reg, dead_b_next;
    logic [PW-1:0]  prod;
    logic [W-1:0]   lim;
    logic           prod_ovf, sq_ovf;

    assign r_small = (res_i[W-1:HW] == '0);
    assign b_small = (z_i[W-1:HW] == '0);
    assign s_op    = r_small ? res_i[HW-1:0] : z_i[HW-1:0];
    assign l_op    = r_small ? z_i : res_i;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_a_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_a_reg    <= res_i;
            x_a_reg      <= x_i;
            y_a_reg      <= y_i;
            z_a_reg      <= z_i;
            exp_a_reg    <= exp_i;
            dead_a_reg   <= dead_i;
            big_a_reg    <= !r_small && !b_small;
            bsmall_a_reg <= b_small;
            plo_a_reg    <= P2W'(l_op[HW-1:0]) * P2W'(s_op);
            phi_a_reg    <= W'(l_op[W-1:HW]) * W'(s_op);
            sq_a_reg     <= P2W'(z_i[HW-1:0]) * P2W'(z_i[HW-1:0]);
        end
    end

    assign prod     = (PW'(phi_a_reg) << HW) + PW'(plo_a_reg);
    assign lim      = {1'b0, {(W-1){1'b1}}} + W'(ctrl_a_reg.neg);
    assign prod_ovf = prod > PW'(lim);
    assign sq_ovf   = sq_a_reg > P2W'(lim);

    always_comb
    begin
        ctrl_b_next = ctrl_a_reg;
        res_b_next  = res_a_reg;
        z_b_next    = z_a_reg;
        dead_b_next = dead_a_reg;
        if (ctrl_a_reg.kind == KIND_POW && ctrl_a_reg.err == ERR_OK)
        begin
            if (exp_a_reg[0])
            begin
                if (dead_a_reg || big_a_reg || prod_ovf)
                begin
                    ctrl_b_next.err = ERR_POW_BIG;
                end
                else
                begin
                    res_b_next = prod[W-1:0];
                end
            end
            if (dead_a_reg || !bsmall_a_reg || sq_ovf)
            begin
                dead_b_next = 1'b1;
            end
            else
            begin
                z_b_next = sq_a_reg[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_b_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_b_reg <= ctrl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_b_reg  <= res_b_next;
            x_b_reg    <= x_a_reg;
            y_b_reg    <= y_a_reg;
            z_b_reg    <= z_b_next;
            exp_b_reg  <= exp_a_reg >> 1;
            dead_b_reg <= dead_b_next;
        end
    end

    assign ctrl_o = ctrl_b_reg;
    assign res_o  = res_b_reg;
    assign x_o    = x_b_reg;
    assign y_o    = y_b_reg;
    assign z_o    = z_b_reg;
    assign exp_o  = exp_b_reg;
    assign dead_o = dead_b_reg;

endmodule

// File: hdl/sia_cell.sv
module sia_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  sia_pkg::ctrl_t        ctrl_i,
    input  logic [DATA_WIDTH-1:0] res_i,
    input  logic [DATA_WIDTH-1:0] x_i,
    input  logic [DATA_WIDTH-1:0] y_i,
    input  logic [DATA_WIDTH-1:0] z_i,
    output sia_pkg::ctrl_t        ctrl_o,
    output logic [DATA_WIDTH-1:0] res_o,
    output logic [DATA_WIDTH-1:0] x_o,
    output logic [DATA_WIDTH-1:0] y_o,
    output logic [DATA_WIDTH-1:0] z_o
);
    import sia_pkg::*;

    localparam int W = DATA_WIDTH;

    // divide: x remainder, y dividend/quotient shifter, z divisor
    // multiply: x accumulator, y multiplier (LSB first), z shifted multiplicand
    ctrl_t        ctrl_reg;
    logic [W-1:0] res_reg, x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [W:0]   trial, diff;
    logic         ge;

    assign trial = {x_i, y_i[W-1]};
    assign diff  = trial - {1'b0, z_i};
    assign ge    = !diff[W];

    always_comb
    begin
        x_next = x_i;
        y_next = y_i;
        z_next = z_i;
        case (ctrl_i.kind)
            KIND_DIV:
            begin
                x_next = ge ? diff[W-1:0] : trial[W-1:0];
                y_next = {y_i[W-2:0], ge};
            end
            KIND_MUL:
            begin
                x_next = x_i + (y_i[0] ? z_i : '0);
                y_next = y_i >> 1;
                z_next = z_i << 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_i;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign res_o  = res_reg;
    assign x_o    = x_reg;
    assign y_o    = y_reg;
    assign z_o    = z_reg;

endmodule

// File: hdl/signed_integer_alu_with_power.sv
// Signed integer ALU with exact power. One beat in carries a command and two
// operands; one beat out carries the value, a boolean flag and an error code.
// The block takes a new beat every cycle while the output beat is not held.
// The pipeline has an entry stage that does the operations needing no cells,
// two stages per exponent bit of the power cells, one cell per bit for
// multiply and divide (shift-add and restoring division), and an output
// register. Every beat goes through the full length, so results leave in
// order. When the output beat is held the whole pipeline holds; in_ready is
// high whenever the output register is empty or being taken.
module signed_integer_alu_with_power #(
    parameter int DATA_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  command,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_value,
    output logic        is_boolean,
    output logic [2:0]  status_code
);
    import sia_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int EW = $clog2(W);

    logic adv;

    // entry stage
    logic [W-1:0]  wa, wb, ma, mb, min_v;
    logic          a_neg, b_neg;
    ctrl_t         c_next, c0_reg;
    logic [W-1:0]  res_next, x_next, y_next, z_next;
    logic [W-1:0]  res0_reg, x0_reg, y0_reg, z0_reg;
    logic [EW-1:0] exp_next, exp0_reg;

    // cell chains
    ctrl_t         pc  [0:EW];
    logic [W-1:0]  pres[0:EW], px[0:EW], py[0:EW], pz[0:EW];
    logic [EW-1:0] pexp[0:EW];
    logic          pdead[0:EW];
    ctrl_t         dc  [0:W];
    logic [W-1:0]  dres[0:W], dx[0:W], dy[0:W], dz[0:W];

    // output stage
    ctrl_t         cl;
    logic [W-1:0]  v_sel, v_fin;
    logic          out_valid_reg;
    logic [63:0]   result_value_reg;
    logic          is_boolean_reg;
    logic [2:0]    status_code_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    assign wa    = operand_a[W-1:0];
    assign wb    = operand_b[W-1:0];
    assign a_neg = wa[W-1];
    assign b_neg = wb[W-1];
    assign ma    = a_neg ? -wa : wa;
    assign mb    = b_neg ? -wb : wb;
    assign min_v = {1'b1, {(W-1){1'b0}}};

    always_comb
    begin
        c_next       = '0;
        c_next.valid = in_valid;
        res_next     = '0;
        x_next       = '0;
        y_next       = '0;
        z_next       = '0;
        exp_next     = '0;
        case (command)
            CMD_POW:
            begin
                if (wa == '0)
                begin
                    if (b_neg)
                        c_next.err = ERR_ZERO_NEG_POW;
                    else
                        res_next = W'(wb == '0);
                end
                else if (wa == W'(1))
                    res_next = W'(1);
                else if (wa == '1)
                    res_next = wb[0] ? '1 : W'(1);
                else if (b_neg)
                    res_next = '0;
                else if (wb >= W'(DATA_WIDTH))
                    c_next.err = ERR_POW_BIG;   // |a| >= 2, so 2**W is already out of range
                else
                begin
                    // square and multiply over the exponent bits
                    c_next.kind = KIND_POW;
                    c_next.neg  = a_neg & wb[0];
                    res_next    = W'(1);
                    z_next      = ma;
                    exp_next    = wb[EW-1:0];
                end
            end
            CMD_MUL:
            begin
                c_next.kind = KIND_MUL;
                y_next      = wb;
                z_next      = wa;
            end
            CMD_DIV, CMD_MOD:
            begin
                if (wb == '0)
                    c_next.err = ERR_DIV_ZERO;
                else if (wa == min_v && wb == '1)
                begin
                    // remainder of MIN by -1 is simply zero
                    if (command == CMD_DIV)
                        c_next.err = ERR_DIV_OVF;
                end
                else
                begin
                    c_next.kind   = KIND_DIV;
                    c_next.is_div = (command == CMD_DIV);
                    c_next.neg    = (command == CMD_DIV) ? (a_neg ^ b_neg) : a_neg;
                    y_next        = ma;
                    z_next        = mb;
                end
            end
            CMD_ADD: res_next = wa + wb;
            CMD_SUB: res_next = wa - wb;
            CMD_SHL, CMD_SHR:
            begin
                if (b_neg || wb >= W'(DATA_WIDTH))
                    c_next.err = ERR_SHIFT;
                else if (command == CMD_SHL)
                    res_next = wa << wb[EW-1:0];
                else
                    res_next = $signed(wa) >>> wb[EW-1:0];
            end
            CMD_LT:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'($signed(wa) < $signed(wb));
            end
            CMD_LE:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'($signed(wa) <= $signed(wb));
            end
            CMD_GT:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'($signed(wa) > $signed(wb));
            end
            CMD_GE:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'($signed(wa) >= $signed(wb));
            end
            CMD_EQ:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'(wa == wb);
            end
            CMD_NE:
            begin
                c_next.is_bool = 1'b1;
                res_next       = W'(wa != wb);
            end
            CMD_AND: res_next = wa & wb;
            CMD_XOR: res_next = wa ^ wb;
            CMD_OR:  res_next = wa | wb;
            CMD_POS: res_next = wa;
            CMD_NEG: res_next = -wa;
            CMD_NOT: res_next = ~wa;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
        end
        else if (adv)
        begin
            c0_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res0_reg <= res_next;
            x0_reg   <= x_next;
            y0_reg   <= y_next;
            z0_reg   <= z_next;
            exp0_reg <= exp_next;
        end
    end

    assign pc[0]    = c0_reg;
    assign pres[0]  = res0_reg;
    assign px[0]    = x0_reg;
    assign py[0]    = y0_reg;
    assign pz[0]    = z0_reg;
    assign pexp[0]  = exp0_reg;
    assign pdead[0] = 1'b0;

    // one power cell per exponent bit, LSB first
    for (genvar i = 0; i < EW; i++)
    begin : g_pow
        sia_pow_cell #(.DATA_WIDTH(DATA_WIDTH)) u_pow (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .ctrl_i (pc[i]),
            .res_i  (pres[i]),
            .x_i    (px[i]),
            .y_i    (py[i]),
            .z_i    (pz[i]),
            .exp_i  (pexp[i]),
            .dead_i (pdead[i]),
            .ctrl_o (pc[i+1]),
            .res_o  (pres[i+1]),
            .x_o    (px[i+1]),
            .y_o    (py[i+1]),
            .z_o    (pz[i+1]),
            .exp_o  (pexp[i+1]),
            .dead_o (pdead[i+1])
        );
    end

    assign dc[0]   = pc[EW];
    assign dres[0] = pres[EW];
    assign dx[0]   = px[EW];
    assign dy[0]   = py[EW];
    assign dz[0]   = pz[EW];

    // one cell per bit: a quotient bit or a multiplier bit each
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        sia_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .ctrl_i (dc[i]),
            .res_i  (dres[i]),
            .x_i    (dx[i]),
            .y_i    (dy[i]),
            .z_i    (dz[i]),
            .ctrl_o (dc[i+1]),
            .res_o  (dres[i+1]),
            .x_o    (dx[i+1]),
            .y_o    (dy[i+1]),
            .z_o    (dz[i+1])
        );
    end

    assign cl = dc[W];

    always_comb
    begin
        case (cl.kind)
            KIND_MUL: v_sel = dx[W];
            KIND_DIV: v_sel = cl.is_div ? dy[W] : dx[W];
            default:  v_sel = dres[W];
        endcase
        v_fin = cl.neg ? -v_sel : v_sel;
        if (cl.err != ERR_OK)
            v_fin = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_value_reg <= 64'($signed(v_fin));
            is_boolean_reg   <= cl.is_bool;
            status_code_reg  <= cl.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign is_boolean   = is_boolean_reg;
    assign status_code  = status_code_reg;

endmodule

// File: hdl/sia_checker.sv
module sia_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [4:0]  command,
    input logic [63:0] operand_a,
    input logic [63:0] operand_b,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_value,
    input logic        is_boolean,
    input logic [2:0]  status_code
);
    import sia_pkg::*;

    // a flagged error always carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_code != ERR_OK |-> result_value == 64'd0)
        else $error("error beat with nonzero value");

    // comparison beats are clean truth values
    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_boolean |->
            (result_value == 64'd0 || result_value == 64'd1) && status_code == ERR_OK)
        else $error("bad boolean beat");

    // an empty output register never back-pressures the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // held output beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(result_value) && $stable(status_code) && $stable(is_boolean))
        else $error("output beat changed while held");

endmodule

bind signed_integer_alu_with_power sia_checker u_sia_checker (.*);
